// ===== design/pds_pkg.sv =====
// Package for the PWM divider solver: widths, limits and shared types.
// Used by pds_div, pwm_divider_solver_top and pds_chk; no dependencies.
`default_nettype none
package pds_pkg;

  localparam int unsigned PERIOD_W    = 16;
  localparam int unsigned ACTIVE_W    = 16;
  localparam int unsigned PRESCALE_W  = 8;
  localparam int unsigned DEAD_ZONE_W = 8;
  localparam int unsigned PULSE_W     = 16;

  localparam int unsigned NUM_W  = 64;   // dividend width of the shared divider
  localparam int unsigned DEN_W  = 32;   // divisor width of the shared divider
  localparam int unsigned CYC_W  = 36;   // rounded source cycle counts
  localparam int unsigned CODE_W = 4;

  localparam logic [DEN_W-1:0]  NS_PER_SEC    = 32'd1000000000;
  localparam logic [31:0]       BYPASS_MAX_NS = 32'd10;
  localparam logic [31:0]       APB_MAX_NS    = 32'd334;
  localparam logic [CODE_W-1:0] LAST_CODE     = 4'd8;
  localparam logic [PRESCALE_W-1:0] LAST_PS   = {PRESCALE_W{1'b1}};

  localparam logic [NUM_W-1:0] PERIOD_LIM = NUM_W'(1) << PERIOD_W;
  localparam logic [NUM_W-1:0] ACTIVE_MAX = (NUM_W'(1) << ACTIVE_W) - NUM_W'(1);
  localparam logic [NUM_W-1:0] DZ_MAX     = (NUM_W'(1) << DEAD_ZONE_W) - NUM_W'(1);
  localparam logic [PULSE_W:0] PULSE_LIM  = (PULSE_W+1)'(1) << PULSE_W;

  // Status codes
  localparam logic [2:0] ST_OK       = 3'd0;
  localparam logic [2:0] ST_INVALID  = 3'd1;
  localparam logic [2:0] ST_DUTY     = 3'd2;
  localparam logic [2:0] ST_NO_CLOCK = 3'd3;
  localparam logic [2:0] ST_NO_DIV   = 3'd4;
  localparam logic [2:0] ST_OVERFLOW = 3'd5;

  // Configuration register indexes
  localparam logic CFG_APB = 1'b0;
  localparam logic CFG_OSC = 1'b1;

  // Divider result toward the sequencer
  typedef struct packed {
    logic             done;
    logic [NUM_W-1:0] quo;
    logic [NUM_W-1:0] quo_rnd;   // quotient rounded up when remainder > den/2
  } div_res_t;

  // One solved result word
  typedef struct packed {
    logic [15:0] pulse_number;
    logic [7:0]  dead_zone_count;
    logic [15:0] active_count;
    logic [15:0] period_count;
    logic [7:0]  prescale_value;
    logic [3:0]  pre_divider_code;
    logic        bypass;
    logic        use_apb_clock;
    logic [2:0]  status;
  } res_t;

endpackage
`default_nettype wire

// ===== design/pds_div.sv =====
// Shared restoring divider, one quotient bit per cycle, 64-bit dividend.
// Depends on pds_pkg.
`default_nettype none
module pds_div
  import pds_pkg::*;
(
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             start_i,
  input  wire logic [NUM_W-1:0] num_i,
  input  wire logic [DEN_W-1:0] den_i,
  output div_res_t              res_o
);

  logic [NUM_W-1:0] quo_q, quo_d;
  logic [DEN_W-1:0] rem_q, rem_d;
  logic [DEN_W-1:0] den_q;
  logic [6:0]       cnt_q, cnt_d;
  logic             busy_q, busy_d;
  logic             done_q, done_d;
  logic [DEN_W:0]   shifted;
  logic             fits;

  // Shift in the next dividend bit and try the subtraction
  assign shifted = {rem_q, quo_q[NUM_W-1]};
  assign fits    = shifted >= {1'b0, den_q};

  always_comb begin
    quo_d  = quo_q;
    rem_d  = rem_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (start_i) begin
      quo_d  = num_i;
      rem_d  = '0;
      cnt_d  = 7'(NUM_W);
      busy_d = 1'b1;
    end else if (busy_q) begin
      quo_d = {quo_q[NUM_W-2:0], fits};
      rem_d = fits ? DEN_W'(shifted - {1'b0, den_q}) : shifted[DEN_W-1:0];
      cnt_d = cnt_q - 7'd1;
      if (cnt_q == 7'd1) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  // Operands need no reset
  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    if (start_i) begin
      den_q <= den_i;
    end
  end

  assign res_o.done    = done_q;
  assign res_o.quo     = quo_q;
  assign res_o.quo_rnd = quo_q + NUM_W'(rem_q > (den_q >> 1));

endmodule
`default_nettype wire

// ===== design/pwm_divider_solver_top.sv =====
// PWM divider solver: one request in, one divider setting and status out.
// A rejected item or a single-mode bypass goes from the check straight to the output
// state. Otherwise each divider setting tried costs one period division, plus one
// dead zone division in bound mode once the period fits. The clock counts and the
// active count take their own divisions. The longest bound-mode search tries the
// period at all 2304 settings. Every division runs in turn on the shared 64-step
// restoring divider, which does each rounding division and each prescale trial.
// The block takes no new request until the current one is solved and its
// result word has moved into the output register. Depends on pds_pkg, pds_div.
`default_nettype none
module pwm_divider_solver_top
  import pds_pkg::*;
(
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  // Configuration write port
  input  wire logic         cfg_we_i,
  input  wire logic         cfg_idx_i,
  input  wire logic [31:0]  cfg_data_i,
  // Request stream
  input  wire logic         s_axis_tvalid,
  output      logic         s_axis_tready,
  // period[31:0], duty_ns[63:32], dead_time_ns[95:64], pulse_mode[96],
  // pulse_count[112:97], zero fill [119:113]
  input  wire logic [119:0] s_axis_tdata,
  // kind[0]
  input  wire logic         s_axis_tuser,
  // Result stream
  output      logic         m_axis_tvalid,
  input  wire logic         m_axis_tready,
  // status[2:0], use_apb_clock[3], bypass[4], pre_divider_code[8:5],
  // prescale_value[16:9], period_count[32:17], active_count[48:33],
  // dead_zone_count[56:49], pulse_number[72:57], zero fill [79:73]
  output      logic [79:0]  m_axis_tdata
);

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_CHECK  = 4'd1;
  localparam logic [3:0] S_CYC_GO = 4'd2;
  localparam logic [3:0] S_CYC_W  = 4'd3;
  localparam logic [3:0] S_DZM    = 4'd4;
  localparam logic [3:0] S_DZC_GO = 4'd5;
  localparam logic [3:0] S_DZC_W  = 4'd6;
  localparam logic [3:0] S_ENT_GO = 4'd7;
  localparam logic [3:0] S_ENT_W  = 4'd8;
  localparam logic [3:0] S_DZ_GO  = 4'd9;
  localparam logic [3:0] S_DZ_W   = 4'd10;
  localparam logic [3:0] S_ACT_M  = 4'd11;
  localparam logic [3:0] S_ACT_GO = 4'd12;
  localparam logic [3:0] S_ACT_W  = 4'd13;
  localparam logic [3:0] S_OUT    = 4'd14;

  logic [3:0]  state_q, state_d;
  logic [31:0] apb_q, osc_q;

  // Request fields
  logic        kind_q;
  logic [31:0] period_q, duty_q, dead_q;
  logic        pmode_q;
  logic [15:0] pcount_q;

  logic [NUM_W-1:0]      prod_q, prod_d;
  logic [CYC_W-1:0]      cyc_q, cyc_d;
  logic [CYC_W-1:0]      dzc_q, dzc_d;
  logic [PERIOD_W:0]     ent_q, ent_d;
  logic [DEAD_ZONE_W-1:0] dz_q, dz_d;
  logic [CODE_W-1:0]     code_q, code_d;
  logic [PRESCALE_W-1:0] ps_q, ps_d;
  logic                  apb_sel_q, apb_sel_d;
  logic                  byp_q, byp_d;
  res_t                  res_q, res_d;
  res_t                  out_q;
  logic                  out_vld_q, out_vld_d;

  logic             div_start;
  logic [NUM_W-1:0] div_num;
  logic [DEN_W-1:0] div_den;
  div_res_t         div_res;
  logic             accept;
  logic             invalid;
  logic [31:0]      clk_sel;
  logic [PERIOD_W:0] ent_fix;

  assign accept        = s_axis_tvalid && s_axis_tready;
  assign s_axis_tready = (state_q == S_IDLE);
  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = {7'd0, out_q};

  assign invalid = (period_q == 32'd0) || (duty_q > period_q) ||
                   (pmode_q && ((pcount_q == 16'd0) || ({1'b0, pcount_q} >= PULSE_LIM)));
  assign clk_sel = (period_q <= APB_MAX_NS) ? apb_q : osc_q;
  assign ent_fix = (ent_q == '0) ? (PERIOD_W+1)'(1) : ent_q;

  pds_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (div_num),
    .den_i   (div_den),
    .res_o   (div_res)
  );

  // Operand select for the shared divider
  always_comb begin
    div_start = 1'b0;
    div_num   = prod_q;
    div_den   = NS_PER_SEC;
    case (state_q)
      S_CYC_GO, S_DZC_GO: div_start = 1'b1;
      S_ENT_GO: begin
        div_start = 1'b1;
        div_num   = NUM_W'(cyc_q >> code_q);
        div_den   = DEN_W'(ps_q) + DEN_W'(1);
      end
      S_DZ_GO: begin
        div_start = 1'b1;
        div_num   = NUM_W'(dzc_q);
        div_den   = (DEN_W'(ps_q) + DEN_W'(1)) << code_q;
      end
      S_ACT_GO: begin
        div_start = 1'b1;
        div_den   = period_q;
      end
      default: ;
    endcase
  end

  // Sequencer
  always_comb begin
    state_d   = state_q;
    prod_d    = prod_q;
    cyc_d     = cyc_q;
    dzc_d     = dzc_q;
    ent_d     = ent_q;
    dz_d      = dz_q;
    code_d    = code_q;
    ps_d      = ps_q;
    apb_sel_d = apb_sel_q;
    byp_d     = byp_q;
    res_d     = res_q;
    out_vld_d = out_vld_q;
    if (out_vld_q && m_axis_tready) begin
      out_vld_d = 1'b0;
    end
    case (state_q)
      S_IDLE: begin
        if (accept) begin
          state_d = S_CHECK;
        end
      end
      S_CHECK: begin
        res_d     = '0;
        byp_d     = (period_q <= BYPASS_MAX_NS);
        apb_sel_d = (period_q <= APB_MAX_NS);
        prod_d    = NUM_W'(clk_sel) * NUM_W'(period_q);
        code_d    = '0;
        ps_d      = '0;
        dz_d      = '0;
        if (invalid) begin
          res_d.status = ST_INVALID;
          state_d      = S_OUT;
        end else if (kind_q && (duty_q < dead_q)) begin
          res_d.status = ST_DUTY;
          state_d      = S_OUT;
        end else if ((period_q <= BYPASS_MAX_NS) && !kind_q) begin
          res_d.use_apb_clock = 1'b1;
          res_d.bypass        = 1'b1;
          state_d             = S_OUT;
        end else if (clk_sel == 32'd0) begin
          res_d.status = ST_NO_CLOCK;
          state_d      = S_OUT;
        end else begin
          state_d = S_CYC_GO;
        end
      end
      S_CYC_GO: state_d = S_CYC_W;
      S_CYC_W: begin
        if (div_res.done) begin
          cyc_d = CYC_W'(div_res.quo_rnd);
          dzc_d = '0;
          state_d = kind_q ? S_DZM : S_ENT_GO;
        end
      end
      S_DZM: begin
        prod_d  = NUM_W'(apb_sel_q ? apb_q : osc_q) * NUM_W'(dead_q);
        state_d = S_DZC_GO;
      end
      S_DZC_GO: state_d = S_DZC_W;
      S_DZC_W: begin
        if (div_res.done) begin
          dzc_d   = CYC_W'(div_res.quo_rnd);
          state_d = S_ENT_GO;
        end
      end
      S_ENT_GO: state_d = S_ENT_W;
      S_ENT_W: begin
        if (div_res.done) begin
          ent_d = div_res.quo[PERIOD_W:0];
          if (div_res.quo <= PERIOD_LIM) begin
            state_d = kind_q ? S_DZ_GO : S_ACT_M;
          end else if (ps_q != LAST_PS) begin
            ps_d    = ps_q + PRESCALE_W'(1);
            state_d = S_ENT_GO;
          end else if (code_q != LAST_CODE) begin
            code_d  = code_q + CODE_W'(1);
            ps_d    = '0;
            state_d = S_ENT_GO;
          end else begin
            res_d.status = ST_NO_DIV;
            state_d      = S_OUT;
          end
        end
      end
      S_DZ_GO: state_d = S_DZ_W;
      S_DZ_W: begin
        if (div_res.done) begin
          dz_d = div_res.quo_rnd[DEAD_ZONE_W-1:0];
          if (div_res.quo_rnd <= DZ_MAX) begin
            state_d = S_ACT_M;
          end else if (ps_q != LAST_PS) begin
            ps_d    = ps_q + PRESCALE_W'(1);
            state_d = S_ENT_GO;
          end else if (code_q != LAST_CODE) begin
            code_d  = code_q + CODE_W'(1);
            ps_d    = '0;
            state_d = S_ENT_GO;
          end else begin
            res_d.status = ST_NO_DIV;
            state_d      = S_OUT;
          end
        end
      end
      S_ACT_M: begin
        prod_d  = NUM_W'(ent_q) * NUM_W'(duty_q);
        state_d = S_ACT_GO;
      end
      S_ACT_GO: state_d = S_ACT_W;
      S_ACT_W: begin
        if (div_res.done) begin
          if (div_res.quo_rnd > ACTIVE_MAX) begin
            res_d.status = ST_OVERFLOW;
          end else begin
            res_d.status           = ST_OK;
            res_d.use_apb_clock    = apb_sel_q;
            res_d.bypass           = byp_q;
            res_d.pre_divider_code = code_q;
            res_d.prescale_value   = ps_q;
            res_d.period_count     = 16'(ent_fix - (PERIOD_W+1)'(1));
            res_d.active_count     = div_res.quo_rnd[15:0];
            res_d.dead_zone_count  = dz_q;
            res_d.pulse_number     = (kind_q && pmode_q) ? (pcount_q - 16'd1) : 16'd0;
          end
          state_d = S_OUT;
        end
      end
      S_OUT: begin
        if (!out_vld_q) begin
          out_vld_d = 1'b1;
          state_d   = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // Control and configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      out_vld_q <= 1'b0;
      apb_q     <= 32'd100000000;
      osc_q     <= 32'd24000000;
    end else begin
      state_q   <= state_d;
      out_vld_q <= out_vld_d;
      if (cfg_we_i && (cfg_idx_i == CFG_APB)) begin
        apb_q <= cfg_data_i;
      end
      if (cfg_we_i && (cfg_idx_i == CFG_OSC)) begin
        osc_q <= cfg_data_i;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (accept) begin
      kind_q   <= s_axis_tuser;
      period_q <= s_axis_tdata[31:0];
      duty_q   <= s_axis_tdata[63:32];
      dead_q   <= s_axis_tdata[95:64];
      pmode_q  <= s_axis_tdata[96];
      pcount_q <= s_axis_tdata[112:97];
    end
    prod_q    <= prod_d;
    cyc_q     <= cyc_d;
    dzc_q     <= dzc_d;
    ent_q     <= ent_d;
    dz_q      <= dz_d;
    code_q    <= code_d;
    ps_q      <= ps_d;
    apb_sel_q <= apb_sel_d;
    byp_q     <= byp_d;
    res_q     <= res_d;
    if ((state_q == S_OUT) && !out_vld_q) begin
      out_q <= res_q;
    end
  end

endmodule
`default_nettype wire

// ===== design/pds_chk.sv =====
// Port-level checker for the PWM divider solver, bound to the top level.
// Depends on pds_pkg and pwm_divider_solver_top.
`default_nettype none
module pds_chk
  import pds_pkg::*;
(
  input wire logic         clk_i,
  input wire logic         rst_ni,
  input wire logic         s_axis_tvalid,
  input wire logic         s_axis_tready,
  input wire logic         m_axis_tvalid,
  input wire logic         m_axis_tready,
  input wire logic [79:0]  m_axis_tdata
);

  // One request at a time: ready drops right after a word is taken
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
    else $error("request accepted while busy");

  // A stalled result word holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))
    else $error("result word changed under stall");

  // An error status clears every other field
  a_err_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && (m_axis_tdata[2:0] != ST_OK)) |-> (m_axis_tdata[79:3] == '0))
    else $error("error result carries data");

  // Bypass always comes from the bus clock
  a_bypass_apb: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tdata[4]) |-> m_axis_tdata[3])
    else $error("bypass without bus clock");

  // Pre-divider code never exceeds the last step
  a_code_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tdata[8:5] <= LAST_CODE))
    else $error("pre-divider code out of range");

endmodule

bind pwm_divider_solver_top pds_chk u_pds_chk (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);
`default_nettype wire
